@@ rtl/pfrd_pkg.sv @@
// shared types, codes and constants of the page frame range database
package pfrd_pkg;

  localparam int ADDR_W   = 48;
  localparam int COUNT_W  = 13;
  localparam int PIDX_W   = 12;
  localparam int FLAG_W   = 3;
  localparam int ACTION_W = 2;
  localparam int TYPE_W   = 4;
  localparam int STATUS_W = 3;

  localparam int DEF_MAX_RANGES = 256;
  localparam int DEF_MAX_PAGES  = 4096;
  localparam int DEF_PAGE_SHIFT = 12;

  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}};

  localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MARK_RSV = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MARK_MD  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SKIPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

  localparam logic [FLAG_W-1:0] FLAG_PRESENT  = 3'b001;
  localparam logic [FLAG_W-1:0] FLAG_RESERVED = 3'b010;
  localparam logic [FLAG_W-1:0] FLAG_METADATA = 3'b100;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   length_bytes;
    logic [COUNT_W-1:0]  page_count;
    logic [TYPE_W-1:0]   mem_type;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PIDX_W-1:0]   page_index;
    logic [ADDR_W-1:0]   page_base;
    logic [FLAG_W-1:0]   page_flags;
  } rsp_t;

  function automatic logic type_usable(input logic [TYPE_W-1:0] t);
    return (t == 4'd1) || (t == 4'd2) || (t == 4'd3) || (t == 4'd4) || (t == 4'd7);
  endfunction

endpackage

@@ rtl/pfrd_flag_ram.sv @@
// per-page flag memory, one write and one registered read a cycle
module pfrd_flag_ram
  import pfrd_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_PAGES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [FLAG_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [FLAG_W-1:0] rdata
);

  logic [FLAG_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/page_frame_range_database.sv @@
// top level: range table, page counters and the scan sequencer
// add: answers straight from idle when refused, else one flag write a page (FLAG_PRESENT)
// mark: answers straight from idle when ignored, else scans every stored range and,
//   for each overlapping range, does a flag read-modify-write on each overlapped page
// lookup: scans the ranges until one holds the address, then reads its page flag on a hit
// one word at a time; reset clears the counters, state and rsp_valid, no clearing pass
module page_frame_range_database
  import pfrd_pkg::*;
#(
  parameter int MAX_RANGES = DEF_MAX_RANGES,
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int RIW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int RCW = $clog2(MAX_RANGES + 1);
  localparam int IW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PCW = $clog2(MAX_PAGES + 1);
  localparam int WI  = ((IW > COUNT_W) ? IW : COUNT_W) + 1;
  localparam int SW  = ((PCW > COUNT_W) ? PCW : COUNT_W) + 1;
  localparam int AW1 = ADDR_W + 1;
  localparam logic [AW1-1:0] PG_MASK = (AW1'(1) << PAGE_SHIFT) - AW1'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_FILL, S_SCAN_RD, S_SCAN_WAIT, S_MK_CMP, S_MK_SPAN,
    S_MK_RD, S_MK_WR, S_LK_CMP, S_LK_RD, S_LK_WAIT
  } state_t;

  state_t state;

  logic [RCW-1:0] ranges_used;
  logic [PCW-1:0] pages_used;
  logic [RCW-1:0] r;
  logic [COUNT_W-1:0] p, last_q, cnt_q;
  logic [WI-1:0] idx_q, mk_idx;
  logic [AW1-1:0] end_q, re_q, off_q, os_q, oe_q;
  logic [ADDR_W-1:0] addr_q, pbase_q;
  logic meta_q, lookup_q;

  logic [ADDR_W-1:0]  rng_base_mem  [MAX_RANGES];
  logic [COUNT_W-1:0] rng_pages_mem [MAX_RANGES];
  logic [IW-1:0]      rng_first_mem [MAX_RANGES];
  logic [ADDR_W-1:0]  rb_q;
  logic [COUNT_W-1:0] rp_q;
  logic [IW-1:0]      rf_q;

  logic              fl_we;
  logic [IW-1:0]     fl_waddr, fl_raddr;
  logic [FLAG_W-1:0] fl_wdata, fl_rdata;

  logic accept, usable, full, add_go, span_bad;
  logic [AW1-1:0] span_end, rb_ext, bytes, d1, d2, first_v, last_v, pg;

  assign accept   = req_valid && req_ready;
  assign req_ready = (state == S_IDLE) && !rsp_valid;
  assign usable   = type_usable(req.mem_type) && (req.page_count != '0);
  assign full     = (ranges_used >= RCW'(MAX_RANGES)) ||
                    ((SW'(pages_used) + SW'(req.page_count)) > SW'(MAX_PAGES));
  assign add_go   = accept && (req.action == ACT_ADD) && usable && !full;
  assign span_end = {1'b0, req.address} + {1'b0, req.length_bytes};
  assign span_bad = (req.length_bytes == '0) || (span_end > {1'b0, ADDR_MASK});

  assign rb_ext  = {1'b0, rb_q};
  assign bytes   = AW1'(rp_q) << PAGE_SHIFT;
  assign d1      = os_q - rb_ext;
  assign d2      = oe_q - rb_ext + PG_MASK;
  assign first_v = d1 >> PAGE_SHIFT;
  assign last_v  = d2 >> PAGE_SHIFT;
  assign pg      = off_q >> PAGE_SHIFT;
  assign mk_idx  = WI'(rf_q) + WI'(p);

  assign fl_we    = (state == S_ADD_FILL) || (state == S_MK_WR);
  assign fl_waddr = IW'(idx_q);
  assign fl_raddr = (state == S_MK_RD) ? IW'(mk_idx) : IW'(idx_q);
  always_comb begin
    if (state == S_ADD_FILL) begin
      fl_wdata = FLAG_PRESENT;
    end else if (meta_q) begin
      fl_wdata = (fl_rdata | FLAG_METADATA) & ~FLAG_PRESENT;
    end else begin
      fl_wdata = fl_rdata | FLAG_RESERVED;
    end
  end

  pfrd_flag_ram #(.DEPTH(MAX_PAGES), .AW(IW)) u_flags (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  // range table
  always_ff @(posedge clk) begin
    if (add_go) begin
      rng_base_mem[ranges_used[RIW-1:0]]  <= req.address;
      rng_pages_mem[ranges_used[RIW-1:0]] <= req.page_count;
      rng_first_mem[ranges_used[RIW-1:0]] <= IW'(pages_used);
    end
    rb_q <= rng_base_mem[r[RIW-1:0]];
    rp_q <= rng_pages_mem[r[RIW-1:0]];
    rf_q <= rng_first_mem[r[RIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ranges_used <= '0;
      pages_used  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            addr_q   <= req.address;
            meta_q   <= (req.action == ACT_MARK_MD);
            lookup_q <= (req.action == ACT_LOOKUP);
            end_q    <= span_end;
            r        <= '0;
            unique case (req.action)
              ACT_ADD: begin
                if (!usable) begin
                  rsp_valid <= 1'b1;
                  rsp       <= '{ST_SKIPPED, '0, '0, '0};
                end else if (full) begin
                  rsp_valid <= 1'b1;
                  rsp       <= '{ST_FULL, '0, '0, '0};
                end else begin
                  idx_q <= WI'(pages_used);
                  p     <= '0;
                  cnt_q <= req.page_count;
                  state <= S_ADD_FILL;
                end
              end
              ACT_MARK_RSV, ACT_MARK_MD: begin
                if (span_bad) begin
                  rsp_valid <= 1'b1;
                  rsp       <= '{ST_IGNORED, '0, '0, '0};
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              default: state <= S_SCAN_RD;
            endcase
          end
        end
        S_ADD_FILL: begin
          if (p == cnt_q - COUNT_W'(1)) begin
            pages_used  <= PCW'(SW'(pages_used) + SW'(cnt_q));
            ranges_used <= ranges_used + RCW'(1);
            rsp_valid   <= 1'b1;
            rsp         <= '{ST_DONE, '0, '0, '0};
            state       <= S_IDLE;
          end else begin
            p     <= p + COUNT_W'(1);
            idx_q <= idx_q + WI'(1);
          end
        end
        S_SCAN_RD: begin
          if (r >= ranges_used) begin
            rsp_valid <= 1'b1;
            rsp       <= '{(lookup_q ? ST_MISS : ST_DONE), '0, '0, '0};
            state     <= S_IDLE;
          end else begin
            state <= S_SCAN_WAIT;
          end
        end
        S_SCAN_WAIT: begin
          re_q  <= rb_ext + bytes;
          off_q <= {1'b0, addr_q} - rb_ext;
          state <= lookup_q ? S_LK_CMP : S_MK_CMP;
        end
        S_MK_CMP: begin
          if (({1'b0, addr_q} >= re_q) || (end_q <= rb_ext)) begin
            r     <= r + RCW'(1);
            state <= S_SCAN_RD;
          end else begin
            os_q  <= ({1'b0, addr_q} > rb_ext) ? {1'b0, addr_q} : rb_ext;
            oe_q  <= (end_q < re_q) ? end_q : re_q;
            state <= S_MK_SPAN;
          end
        end
        S_MK_SPAN: begin
          p      <= COUNT_W'(first_v);
          last_q <= (last_v > AW1'(rp_q)) ? rp_q : COUNT_W'(last_v);
          state  <= S_MK_RD;
        end
        S_MK_RD: begin
          if ((p >= last_q) || (mk_idx >= WI'(MAX_PAGES))) begin
            r     <= r + RCW'(1);
            state <= S_SCAN_RD;
          end else begin
            idx_q <= mk_idx;
            state <= S_MK_WR;
          end
        end
        S_MK_WR: begin
          p     <= p + COUNT_W'(1);
          state <= S_MK_RD;
        end
        S_LK_CMP: begin
          if (off_q[ADDR_W] || (off_q >= bytes)) begin
            r     <= r + RCW'(1);
            state <= S_SCAN_RD;
          end else begin
            idx_q   <= WI'(rf_q) + WI'(COUNT_W'(pg));
            pbase_q <= rb_q + (off_q[ADDR_W-1:0] & ~PG_MASK[ADDR_W-1:0]);
            state   <= S_LK_RD;
          end
        end
        S_LK_RD: begin
          state <= S_LK_WAIT;
        end
        S_LK_WAIT: begin
          rsp_valid <= 1'b1;
          rsp       <= '{ST_DONE, PIDX_W'(idx_q), pbase_q,
                         ((idx_q < WI'(MAX_PAGES)) ? fl_rdata : '0)};
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ranges_bound: assert property (@(posedge clk) disable iff (rst)
    ranges_used <= RCW'(MAX_RANGES))
    else $error("range count past table size");

  a_pages_bound: assert property (@(posedge clk) disable iff (rst)
    SW'(pages_used) <= SW'(MAX_PAGES))
    else $error("page count past page store");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req_ready)
    else $error("ready straight after an accepted word");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fl_we |-> (idx_q < WI'(MAX_PAGES)))
    else $error("flag write outside page store");

endmodule
